// ----- sv/msg_pkg.sv -----
package msg_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [2:0] {
		ST_READY = 3'd0,
		ST_GEN   = 3'd1,
		ST_CNEG  = 3'd2,
		ST_CPOS  = 3'd3,
		ST_DONE  = 3'd4
	} motion_state_t;

	typedef enum logic [1:0] {
		REQ_MOVE  = 2'd0,
		REQ_STOP  = 2'd1,
		REQ_RESET = 2'd2,
		REQ_CHECK = 2'd3
	} req_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_AUTO_RESET      = 3'd0,
		CFG_START_POSITION  = 3'd1,
		CFG_TARGET_POSITION = 3'd2,
		CFG_FINITE_STEP     = 3'd3,
		CFG_CONT_STEP       = 3'd4,
		CFG_CYCLE_TIMES     = 3'd5,
		CFG_TRAVEL_MIN      = 3'd6,
		CFG_TRAVEL_MAX      = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic               auto_reset;
		logic signed [31:0] start_position;
		logic signed [31:0] target_position;
		logic [30:0]        finite_step;
		logic [30:0]        cont_step;
		logic [15:0]        cycle_times;
		logic signed [31:0] travel_min;
		logic signed [31:0] travel_max;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		auto_reset:      1'b1,
		start_position:  32'sh0000_0000,
		target_position: 32'sh0000_0000,
		finite_step:     31'h0,
		cont_step:       31'h0,
		cycle_times:     16'h0A0A,
		travel_min:      32'sh8000_0000,
		travel_max:      32'sh7FFF_FFFF
	};

	typedef struct packed {
		req_t               req_type;
		logic               continuous;
		logic               trigger;
		logic               direction;
		logic signed [31:0] move_start;
		logic [31:0]        now_ms;
		logic signed [31:0] checked_position;
		logic signed [31:0] sensitivity;
	} item_t;

	typedef struct packed {
		motion_state_t      mode;
		logic [31:0]        last_step_time;
		logic signed [31:0] cont_step_signed;
		logic               starting;
		logic               neg_limit;
		logic               pos_limit;
	} gen_state_t;

	localparam gen_state_t GEN_RESET = '{
		mode:             ST_READY,
		last_step_time:   32'h0,
		cont_step_signed: 32'sh0,
		starting:         1'b0,
		neg_limit:        1'b0,
		pos_limit:        1'b0
	};

	typedef struct packed {
		logic signed [31:0] setpoint;
		logic               motion_pulse;
		logic               starting;
		logic               ending;
		motion_state_t      motion_state;
		logic               neg_limit_hit;
		logic               pos_limit_hit;
	} result_t;

endpackage

// ----- sv/motion_setpoint_generator.sv -----
// Constant-velocity setpoint generator. Takes one request beat per clock cycle while
// in_ready is high and returns exactly one result beat for it: the request lands in an
// input register, one pass of the step logic updates the motion state and setpoint,
// and the result waits in an output register, so while a result is stalled one more
// request is still taken into the input register before the input stalls. Move calls
// step the Q16.16 setpoint by the programmed increment once the cycle time has elapsed
// against now_ms, land finite moves on the target and clamp at the travel limits.
// Registers may be written only while no request is in flight, and take effect on the
// next request.
module motion_setpoint_generator #(
	parameter int POS_WIDTH    = 32,
	parameter int MIN_CYCLE_MS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [msg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [msg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic                             continuous,
	input  logic                             trigger,
	input  logic                             direction,
	input  logic signed [31:0]               move_start,
	input  logic [31:0]                      now_ms,
	input  logic signed [31:0]               checked_position,
	input  logic signed [31:0]               sensitivity,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [31:0]               setpoint,
	output logic                             motion_pulse,
	output logic                             starting,
	output logic                             ending,
	output logic [2:0]                       motion_state,
	output logic                             neg_limit_hit,
	output logic                             pos_limit_hit
);

	msg_pkg::cfg_t              cfg;
	msg_pkg::item_t             in_item, item_s1;
	logic                       valid_s1, adv;
	msg_pkg::gen_state_t        gen_q, gen_nxt;
	logic signed [POS_WIDTH-1:0] setpoint_q, setpoint_nxt;
	msg_pkg::result_t           result, result_q;
	logic                       out_valid_q;

	msg_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	always_comb begin
		in_item.req_type         = msg_pkg::req_t'(req_type);
		in_item.continuous       = continuous;
		in_item.trigger          = trigger;
		in_item.direction        = direction;
		in_item.move_start       = move_start;
		in_item.now_ms           = now_ms;
		in_item.checked_position = checked_position;
		in_item.sensitivity      = sensitivity;
	end

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	msg_step #(
		.POS_WIDTH    (POS_WIDTH),
		.MIN_CYCLE_MS (MIN_CYCLE_MS)
	) u_step (
		.item         (item_s1),
		.cur          (gen_q),
		.setpoint_cur (setpoint_q),
		.cfg          (cfg),
		.nxt          (gen_nxt),
		.setpoint_nxt (setpoint_nxt),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q      <= msg_pkg::GEN_RESET;
			setpoint_q <= '0;
		end else if (adv) begin
			gen_q      <= gen_nxt;
			setpoint_q <= setpoint_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign setpoint      = result_q.setpoint;
	assign motion_pulse  = result_q.motion_pulse;
	assign starting      = result_q.starting;
	assign ending        = result_q.ending;
	assign motion_state  = result_q.motion_state;
	assign neg_limit_hit = result_q.neg_limit_hit;
	assign pos_limit_hit = result_q.pos_limit_hit;

	// a pulse only leaves a moving state
	a_pulse_moving: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.motion_pulse) |->
			(result_q.motion_state == msg_pkg::ST_GEN
			|| result_q.motion_state == msg_pkg::ST_CNEG
			|| result_q.motion_state == msg_pkg::ST_CPOS))
		else $error("motion pulse outside a moving state");

	a_ending_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.ending) |->
			(result_q.motion_state == msg_pkg::ST_READY
			|| result_q.motion_state == msg_pkg::ST_DONE))
		else $error("ending reported while still moving");

	a_cpos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_q.mode == msg_pkg::ST_CPOS) |-> (gen_q.cont_step_signed > 32'sd0))
		else $error("positive continuous motion without positive increment");

	a_cneg_step: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_q.mode == msg_pkg::ST_CNEG) |-> (gen_q.cont_step_signed < 32'sd0))
		else $error("negative continuous motion without negative increment");

endmodule

// ----- sv/msg_cfg_regs.sv -----
module msg_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [msg_pkg::CFG_INDEX_W-1:0]  index,
	input  logic [msg_pkg::CFG_DATA_W-1:0]   data,
	output msg_pkg::cfg_t                    cfg
);

	msg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= msg_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (msg_pkg::cfg_idx_t'(index))
				msg_pkg::CFG_AUTO_RESET:      cfg_q.auto_reset      <= data[0];
				msg_pkg::CFG_START_POSITION:  cfg_q.start_position  <= data[31:0];
				msg_pkg::CFG_TARGET_POSITION: cfg_q.target_position <= data[31:0];
				msg_pkg::CFG_FINITE_STEP:     cfg_q.finite_step     <= data[30:0];
				msg_pkg::CFG_CONT_STEP:       cfg_q.cont_step       <= data[30:0];
				msg_pkg::CFG_CYCLE_TIMES:     cfg_q.cycle_times     <= data[15:0];
				msg_pkg::CFG_TRAVEL_MIN:      cfg_q.travel_min      <= data[31:0];
				msg_pkg::CFG_TRAVEL_MAX:      cfg_q.travel_max      <= data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/msg_step.sv -----
module msg_step #(
	parameter int POS_WIDTH    = 32,
	parameter int MIN_CYCLE_MS = 10
) (
	input  msg_pkg::item_t                item,
	input  msg_pkg::gen_state_t           cur,
	input  logic signed [POS_WIDTH-1:0]   setpoint_cur,
	input  msg_pkg::cfg_t                 cfg,
	output msg_pkg::gen_state_t           nxt,
	output logic signed [POS_WIDTH-1:0]   setpoint_nxt,
	output msg_pkg::result_t              result
);

	localparam int EW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 2;
	localparam logic signed [EW-1:0] POS_MAX_E =
		{{(EW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [EW-1:0] POS_MIN_E = ~POS_MAX_E;
	localparam logic [7:0] MIN_CYC = 8'(MIN_CYCLE_MS);

	function automatic logic signed [EW-1:0] sx32(input logic [31:0] v);
		return {{(EW-32){v[31]}}, v};
	endfunction

	function automatic logic signed [EW-1:0] clamp_e(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] r;
		if (v > POS_MAX_E) begin
			r = POS_MAX_E;
		end else if (v < POS_MIN_E) begin
			r = POS_MIN_E;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic signed [EW-1:0] p_cur_e, tmin_e, tmax_e, tgt_e, start_e;
	logic signed [EW-1:0] base_e, fstep_e, cstep_e, inc_f_e, sc_e;
	logic signed [EW-1:0] absd_e, sum_e, raw_e, lim_e, p_step_e, p_new_e;
	logic                 ready_st, fin_pos, dpos, allowed, big, step_ok;
	logic                 elapsed, matched, active, zero_step, stop, pulse;
	logic [7:0]           cyc_raw, cyc;
	logic [31:0]          last_plus;
	logic signed [33:0]   cp_e, lo_e, hi_e, dlo, dhi, adlo, adhi, sens_raw, sens_e;

	assign p_cur_e  = EW'(setpoint_cur);
	assign tmin_e   = sx32(cfg.travel_min);
	assign tmax_e   = sx32(cfg.travel_max);
	assign tgt_e    = sx32(cfg.target_position);
	assign start_e  = sx32(cfg.start_position);
	assign ready_st = (cur.mode == msg_pkg::ST_READY);

	// on a start from ready the setpoint first jumps to the start position (move_start for continuous moves)
	assign base_e = ready_st
		? (item.continuous ? clamp_e(sx32(item.move_start)) : clamp_e(start_e))
		: p_cur_e;

	assign fin_pos = !(tgt_e < start_e);
	assign fstep_e = {{(EW-31){1'b0}}, cfg.finite_step};
	assign cstep_e = {{(EW-31){1'b0}}, cfg.cont_step};
	assign inc_f_e = fin_pos ? fstep_e : -fstep_e;
	assign sc_e    = ready_st ? (item.direction ? cstep_e : -cstep_e)
		: sx32(cur.cont_step_signed);

	assign dpos    = item.continuous ? item.direction : fin_pos;
	assign allowed = dpos ? (base_e < tmax_e) : (base_e > tmin_e);

	assign absd_e = (tgt_e >= base_e) ? (tgt_e - base_e) : (base_e - tgt_e);
	assign big    = (absd_e >= fstep_e);
	assign sum_e  = base_e + (item.continuous ? sc_e : inc_f_e);
	assign raw_e  = (item.continuous || big) ? clamp_e(sum_e) : clamp_e(tgt_e);

	// clamp at the travel limit in the direction of motion
	assign lim_e = (dpos && (raw_e >= tmax_e)) ? clamp_e(tmax_e)
		: ((!dpos && (raw_e <= tmin_e)) ? clamp_e(tmin_e) : raw_e);

	assign step_ok  = allowed && (item.continuous ? item.trigger
		: (big || (tgt_e != base_e)));
	assign p_step_e = step_ok ? lim_e : base_e;

	assign cyc_raw   = item.continuous ? cfg.cycle_times[15:8] : cfg.cycle_times[7:0];
	assign cyc       = (cyc_raw < MIN_CYC) ? MIN_CYC : cyc_raw;
	assign elapsed   = ((item.now_ms - cur.last_step_time) >= {24'h0, cyc});
	assign last_plus = cur.last_step_time + {24'h0, cyc};

	assign matched = (!item.continuous && (cur.mode == msg_pkg::ST_GEN))
		|| ((cur.mode == msg_pkg::ST_CNEG) && !item.direction)
		|| ((cur.mode == msg_pkg::ST_CPOS) && item.direction);
	assign active    = item.continuous || (cur.mode == msg_pkg::ST_GEN);
	assign zero_step = item.continuous ? (cfg.cont_step == '0) : (cfg.finite_step == '0);

	assign cp_e     = 34'(item.checked_position);
	assign lo_e     = 34'(cfg.travel_min);
	assign hi_e     = 34'(cfg.travel_max);
	assign dlo      = cp_e - lo_e;
	assign dhi      = cp_e - hi_e;
	assign adlo     = (dlo < 0) ? -dlo : dlo;
	assign adhi     = (dhi < 0) ? -dhi : dhi;
	assign sens_raw = 34'(item.sensitivity);
	assign sens_e   = (sens_raw < 0) ? -sens_raw : sens_raw;

	always_comb begin
		nxt     = cur;
		p_new_e = p_cur_e;
		pulse   = 1'b0;
		stop    = 1'b0;
		case (item.req_type)
			msg_pkg::REQ_MOVE: begin
				if (ready_st) begin
					nxt.starting = 1'b0;
					if (item.trigger && !zero_step) begin
						if (!item.continuous) begin
							nxt.mode = msg_pkg::ST_GEN;
						end else if (item.direction) begin
							nxt.mode = msg_pkg::ST_CPOS;
						end else begin
							nxt.mode = msg_pkg::ST_CNEG;
						end
						if (item.continuous) begin
							nxt.cont_step_signed = sc_e[31:0];
						end
						nxt.last_step_time = item.now_ms;
						p_new_e = p_step_e;
						if (step_ok) begin
							nxt.starting = 1'b1;
							pulse        = 1'b1;
						end
					end
				end else if (matched) begin
					nxt.starting = 1'b0;
					if (active && elapsed) begin
						nxt.last_step_time = last_plus;
						if (step_ok) begin
							p_new_e = lim_e;
							pulse   = 1'b1;
						end else begin
							stop = 1'b1;
						end
					end
				end else if (cur.mode == msg_pkg::ST_DONE) begin
					if (cfg.auto_reset) begin
						nxt.mode = msg_pkg::ST_READY;
					end
				end
			end
			msg_pkg::REQ_STOP: begin
				stop = item.trigger;
			end
			msg_pkg::REQ_RESET: begin
				nxt.mode = msg_pkg::ST_READY;
			end
			msg_pkg::REQ_CHECK: begin
				nxt.neg_limit = (cp_e < lo_e) || (adlo <= sens_e);
				nxt.pos_limit = (cp_e > hi_e) || (adhi <= sens_e);
			end
			default: ;
		endcase
		if (stop) begin
			if (cfg.auto_reset) begin
				nxt.mode = msg_pkg::ST_READY;
			end else begin
				nxt.mode = msg_pkg::ST_DONE;
			end
		end
	end

	assign setpoint_nxt = p_new_e[POS_WIDTH-1:0];

	always_comb begin
		result.setpoint      = p_new_e[31:0];
		result.motion_pulse  = pulse;
		result.starting      = nxt.starting;
		result.ending        = stop;
		result.motion_state  = nxt.mode;
		result.neg_limit_hit = nxt.neg_limit;
		result.pos_limit_hit = nxt.pos_limit;
	end

endmodule

// ----- tb/sv/tb_motion_setpoint_generator.sv -----
`timescale 1ns / 1ps

module tb_motion_setpoint_generator;

	localparam longint SET_MAX = 64'sd2147483647;
	localparam longint SET_MIN = -64'sd2147483648;
	localparam int MIN_CYCLE = 10;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = '0;
	logic        continuous = 1'b0;
	logic        trigger = 1'b0;
	logic        direction = 1'b0;
	logic [31:0] move_start = '0;
	logic [31:0] now_ms = '0;
	logic [31:0] checked_position = '0;
	logic [31:0] sensitivity = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] setpoint;
	logic        motion_pulse;
	logic        starting;
	logic        ending;
	logic [2:0]  motion_state;
	logic        neg_limit_hit;
	logic        pos_limit_hit;

	motion_setpoint_generator DUT (.*);

	// shadow of the register file and of the generator
	msg_pkg::cfg_t          shadow_cfg;
	msg_pkg::motion_state_t gen_mode;
	longint        gen_setpoint;
	longint        gen_cont_inc;
	logic [31:0]   gen_last_ms;
	bit            gen_new_pos, gen_starting, gen_ending, gen_neg_hit, gen_pos_hit;

	msg_pkg::item_t   request_q[$];
	msg_pkg::result_t due_results[$];
	msg_pkg::item_t   beat_req;
	int      send_idle_pct = 21;
	int      recv_idle_pct = 69;
	int      fault_count = 0;
	logic [31:0] clock_ms;

	function automatic longint clip(longint v);
		if (v > SET_MAX) return SET_MAX;
		if (v < SET_MIN) return SET_MIN;
		return v;
	endfunction

	function automatic logic [31:0] cycle_ms(bit cont_sel);
		logic [7:0] c;
		c = cont_sel ? shadow_cfg.cycle_times[15:8] : shadow_cfg.cycle_times[7:0];
		return (c < MIN_CYCLE) ? MIN_CYCLE : c;
	endfunction

	function automatic bit room_to_move(longint p, bit pos);
		longint lo, hi;
		lo = $signed(shadow_cfg.travel_min);
		hi = $signed(shadow_cfg.travel_max);
		if (!pos && p <= lo) return 0;
		if (pos && p >= hi) return 0;
		return 1;
	endfunction

	function automatic void stop_at_limit(bit pos);
		longint lo, hi;
		lo = $signed(shadow_cfg.travel_min);
		hi = $signed(shadow_cfg.travel_max);
		if (pos && gen_setpoint >= hi)
			gen_setpoint = hi;
		else if (!pos && gen_setpoint <= lo)
			gen_setpoint = lo;
	endfunction

	function automatic bit finite_advance();
		longint tgt, org, inc, gap, stepv;
		bit pos;
		tgt = $signed(shadow_cfg.target_position);
		org = $signed(shadow_cfg.start_position);
		stepv = shadow_cfg.finite_step;
		pos = !(tgt < org);
		inc = pos ? stepv : -stepv;
		if (!room_to_move(gen_setpoint, pos)) return 0;
		gap = (tgt >= gen_setpoint) ? tgt - gen_setpoint : gen_setpoint - tgt;
		if (gap >= stepv)
			gen_setpoint = clip(gen_setpoint + inc);
		else if (tgt != gen_setpoint)
			gen_setpoint = tgt;
		else
			return 0;
		stop_at_limit(pos);
		return 1;
	endfunction

	function automatic bit cont_advance(bit cmd, bit dir);
		if (!room_to_move(gen_setpoint, dir) || !cmd) return 0;
		gen_setpoint = clip(gen_setpoint + gen_cont_inc);
		stop_at_limit(dir);
		return 1;
	endfunction

	function automatic bit finite_call(logic [31:0] now);
		logic [31:0] c, elapsed;
		if (gen_mode == msg_pkg::ST_READY) begin
			gen_new_pos = 0;
			if (shadow_cfg.finite_step == 0) return 0;
			gen_mode = msg_pkg::ST_GEN;
			gen_last_ms = now;
			gen_setpoint = $signed(shadow_cfg.start_position);
			return finite_advance();
		end
		if (gen_mode == msg_pkg::ST_GEN) begin
			c = cycle_ms(0);
			elapsed = now - gen_last_ms;
			if (elapsed >= c) begin
				gen_last_ms = gen_last_ms + c;
				gen_new_pos = 1;
				return finite_advance();
			end
		end
		return 1;
	endfunction

	function automatic bit cont_call(bit cmd, bit dir, logic [31:0] org, logic [31:0] now);
		logic [31:0] c, elapsed;
		longint stepv;
		if (gen_mode == msg_pkg::ST_READY) begin
			gen_new_pos = 0;
			if (shadow_cfg.cont_step == 0) return 0;
			stepv = shadow_cfg.cont_step;
			gen_mode = dir ? msg_pkg::ST_CPOS : msg_pkg::ST_CNEG;
			gen_cont_inc = dir ? stepv : -stepv;
			gen_last_ms = now;
			gen_setpoint = longint'($signed(org));
			return cont_advance(cmd, dir);
		end
		if ((gen_mode == msg_pkg::ST_CNEG && !dir) || (gen_mode == msg_pkg::ST_CPOS && dir)) begin
			c = cycle_ms(1);
			elapsed = now - gen_last_ms;
			if (elapsed >= c) begin
				gen_last_ms = gen_last_ms + c;
				gen_new_pos = 1;
				return cont_advance(cmd, dir);
			end
		end
		return 1;
	endfunction

	function automatic void stop_motion();
		gen_ending = 1;
		gen_mode = shadow_cfg.auto_reset ? msg_pkg::ST_READY : msg_pkg::ST_DONE;
	endfunction

	function automatic msg_pkg::result_t predict_result(msg_pkg::item_t it);
		msg_pkg::result_t r;
		bit pulse, ok;
		longint cp, lo, hi, sens, dlo, dhi;
		pulse = 0;
		case (it.req_type)
			msg_pkg::REQ_MOVE: begin
				if (gen_mode == msg_pkg::ST_READY) begin
					gen_starting = 0;
					gen_ending = 0;
					if (it.trigger) begin
						ok = it.continuous ?
							cont_call(it.trigger, it.direction, it.move_start, it.now_ms) :
							finite_call(it.now_ms);
						if (ok) begin
							gen_starting = 1;
							pulse = 1;
						end
					end
				end else if ((!it.continuous && gen_mode == msg_pkg::ST_GEN) ||
						(gen_mode == msg_pkg::ST_CNEG && !it.direction) ||
						(gen_mode == msg_pkg::ST_CPOS && it.direction)) begin
					gen_starting = 0;
					ok = it.continuous ?
						cont_call(it.trigger, it.direction, it.move_start, it.now_ms) :
						finite_call(it.now_ms);
					if (ok) begin
						if (gen_new_pos) begin
							gen_new_pos = 0;
							pulse = 1;
						end
					end else begin
						stop_motion();
					end
				end else if (gen_mode == msg_pkg::ST_DONE) begin
					gen_ending = 0;
					if (shadow_cfg.auto_reset) gen_mode = msg_pkg::ST_READY;
				end
			end
			msg_pkg::REQ_STOP: begin
				if (it.trigger) stop_motion();
			end
			msg_pkg::REQ_RESET: begin
				gen_mode = msg_pkg::ST_READY;
			end
			default: begin
				cp = $signed(it.checked_position);
				sens = $signed(it.sensitivity);
				if (sens < 0) sens = -sens;
				lo = $signed(shadow_cfg.travel_min);
				hi = $signed(shadow_cfg.travel_max);
				dlo = (cp >= lo) ? cp - lo : lo - cp;
				dhi = (cp >= hi) ? cp - hi : hi - cp;
				gen_neg_hit = (cp < lo) || (dlo <= sens);
				gen_pos_hit = (cp > hi) || (dhi <= sens);
			end
		endcase
		r.setpoint = gen_setpoint[31:0];
		r.motion_pulse = pulse;
		r.starting = gen_starting;
		r.ending = gen_ending;
		r.motion_state = gen_mode;
		r.neg_limit_hit = gen_neg_hit;
		r.pos_limit_hit = gen_pos_hit;
		gen_ending = 0;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fault_count++;
		end
	endfunction

	function automatic logic [31:0] pick_between(longint a, longint b);
		longint unsigned span;
		if (b < a) return $urandom;
		span = longint'(b - a) + 1;
		return 32'(a + longint'({$urandom, $urandom} % span));
	endfunction

	function automatic logic [7:0] pick_cycle();
		case ($urandom_range(19))
			0, 1, 2: return 8'($urandom_range(MIN_CYCLE - 1));
			3, 4, 5: return 8'($urandom_range(255));
			default: return 8'($urandom_range(30, MIN_CYCLE));
		endcase
	endfunction

	task automatic queue_req(msg_pkg::req_t rt, bit cont, bit trig, bit dir, logic [31:0] org,
			logic [31:0] cp, logic [31:0] sens);
		msg_pkg::item_t it;
		it.req_type = rt;
		it.continuous = cont;
		it.trigger = trig;
		it.direction = dir;
		it.move_start = org;
		it.now_ms = clock_ms;
		it.checked_position = cp;
		it.sensitivity = sens;
		request_q.push_back(it);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (request_q.size() != 0 || in_valid || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(msg_pkg::cfg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			msg_pkg::CFG_AUTO_RESET:      shadow_cfg.auto_reset = value[0];
			msg_pkg::CFG_START_POSITION:  shadow_cfg.start_position = value;
			msg_pkg::CFG_TARGET_POSITION: shadow_cfg.target_position = value;
			msg_pkg::CFG_FINITE_STEP:     shadow_cfg.finite_step = value[30:0];
			msg_pkg::CFG_CONT_STEP:       shadow_cfg.cont_step = value[30:0];
			msg_pkg::CFG_CYCLE_TIMES:     shadow_cfg.cycle_times = value[15:0];
			msg_pkg::CFG_TRAVEL_MIN:      shadow_cfg.travel_min = value;
			msg_pkg::CFG_TRAVEL_MAX:      shadow_cfg.travel_max = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_session(output int issued);
		longint lo, hi, st, tg, gap, stepv, span, cp;
		logic [31:0] cyc, sens;
		int n, k, r, mode_pick;
		bit cont, dir;
		drain();
		case ($urandom_range(3))
			0: begin
				lo = SET_MIN;
				hi = SET_MAX;
			end
			1: begin
				lo = -longint'($urandom_range(32'h4000_0000, 32'h0001_0000));
				hi = $urandom_range(32'h4000_0000, 32'h0001_0000);
			end
			2: begin
				lo = $signed($urandom);
				hi = $signed($urandom);
			end
			default: begin
				lo = -longint'($urandom_range(32'h0010_0000));
				hi = lo + $urandom_range(32'h0010_0000);
			end
		endcase
		st = ($urandom_range(9) == 0) ? $signed($urandom) : $signed(pick_between(lo, hi));
		tg = ($urandom_range(9) == 0) ? $signed($urandom) : $signed(pick_between(lo, hi));
		gap = (tg > st) ? tg - st : st - tg;
		case ($urandom_range(19))
			0: stepv = 0;
			1: stepv = 32'h7FFF_FFFF;
			2: stepv = $urandom_range(32'h7FFF_FFFF);
			default: stepv = gap / $urandom_range(12, 1) + $urandom_range(255);
		endcase
		if (stepv > 32'h7FFF_FFFF) stepv = 32'h7FFF_FFFF;
		span = (hi > lo) ? hi - lo : 32'h0010_0000;
		write_reg(msg_pkg::CFG_AUTO_RESET, $urandom_range(1));
		write_reg(msg_pkg::CFG_START_POSITION, st[31:0]);
		write_reg(msg_pkg::CFG_TARGET_POSITION, tg[31:0]);
		write_reg(msg_pkg::CFG_FINITE_STEP, stepv[31:0]);
		case ($urandom_range(19))
			0: stepv = 0;
			1: stepv = 32'h7FFF_FFFF;
			2: stepv = $urandom_range(32'h7FFF_FFFF);
			default: stepv = span / $urandom_range(30, 4) + $urandom_range(255);
		endcase
		if (stepv > 32'h7FFF_FFFF) stepv = 32'h7FFF_FFFF;
		write_reg(msg_pkg::CFG_CONT_STEP, stepv[31:0]);
		write_reg(msg_pkg::CFG_CYCLE_TIMES, {16'h0, pick_cycle(), pick_cycle()});
		write_reg(msg_pkg::CFG_TRAVEL_MIN, lo[31:0]);
		write_reg(msg_pkg::CFG_TRAVEL_MAX, hi[31:0]);

		case ($urandom_range(9))
			0: clock_ms = $urandom;
			1: clock_ms = 32'hFFFF_FFFF - $urandom_range(200);
			default: ;
		endcase
		mode_pick = $urandom_range(2);
		n = $urandom_range(45, 20);
		for (k = 0; k < n; k++) begin
			cyc = cycle_ms(mode_pick != 0);
			r = $urandom_range(19);
			if (r == 0)
				clock_ms = clock_ms + $urandom;
			else if (r > 2)
				clock_ms = clock_ms + $urandom_range(cyc + cyc / 2);
			r = $urandom_range(99);
			if (r < 70) begin
				cont = mode_pick != 0;
				dir = mode_pick == 2;
				queue_req(msg_pkg::REQ_MOVE, cont, $urandom_range(15) != 0, dir,
					pick_between(lo, hi), $urandom, $urandom);
			end else if (r < 80) begin
				if ($urandom_range(3) == 0)
					cp = $signed($urandom);
				else
					cp = ($urandom_range(1) ? lo : hi) + $signed($urandom_range(32'h2000)) - 32'h1000;
				sens = $urandom_range(32'h2000);
				if ($urandom_range(1)) sens = -sens;
				if ($urandom_range(7) == 0) sens = $urandom;
				queue_req(msg_pkg::REQ_CHECK, $urandom_range(1), $urandom_range(1),
					$urandom_range(1), $urandom, cp[31:0], sens);
			end else if (r < 86) begin
				queue_req(msg_pkg::REQ_STOP, $urandom_range(1), $urandom_range(3) != 0,
					$urandom_range(1), $urandom, $urandom, $urandom);
			end else if (r < 89) begin
				queue_req(msg_pkg::REQ_RESET, $urandom_range(1), $urandom_range(1),
					$urandom_range(1), $urandom, $urandom, $urandom);
			end else if (r < 95) begin
				queue_req(msg_pkg::REQ_MOVE, $urandom_range(1), $urandom_range(1),
					$urandom_range(1), pick_between(lo, hi), $urandom, $urandom);
			end else begin
				queue_req(msg_pkg::req_t'($urandom_range(3)), $urandom_range(1),
					$urandom_range(1), $urandom_range(1), $urandom, $urandom, $urandom);
			end
			if ($urandom_range(49) == 0) mode_pick = $urandom_range(2);
		end
		issued = n;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(8_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	// request side
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				due_results.push_back(predict_result(beat_req));
			end
			if (!in_valid || in_ready) begin
				if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					beat_req = request_q.pop_front();
					in_valid <= 1'b1;
					req_type <= beat_req.req_type;
					continuous <= beat_req.continuous;
					trigger <= beat_req.trigger;
					direction <= beat_req.direction;
					move_start <= beat_req.move_start;
					now_ms <= beat_req.now_ms;
					checked_position <= beat_req.checked_position;
					sensitivity <= beat_req.sensitivity;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk) begin
		msg_pkg::result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result beat with nothing outstanding");
					fault_count++;
				end else begin
					want = due_results.pop_front();
					check_field("setpoint", want.setpoint, setpoint);
					check_field("motion_pulse", want.motion_pulse, motion_pulse);
					check_field("starting", want.starting, starting);
					check_field("ending", want.ending, ending);
					check_field("motion_state", want.motion_state, motion_state);
					check_field("neg_limit_hit", want.neg_limit_hit, neg_limit_hit);
					check_field("pos_limit_hit", want.pos_limit_hit, pos_limit_hit);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int total, got, guard;
		shadow_cfg = msg_pkg::CFG_RESET;
		gen_mode = msg_pkg::ST_READY;
		gen_setpoint = 0;
		gen_cont_inc = 0;
		gen_last_ms = '0;
		gen_new_pos = 0;
		gen_starting = 0;
		gen_ending = 0;
		gen_neg_hit = 0;
		gen_pos_hit = 0;
		clock_ms = 32'hFFFF_FFF0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults: zero steps, full travel
		queue_req(msg_pkg::REQ_MOVE, 1'b0, 1'b1, 1'b0, '0, '0, '0);
		queue_req(msg_pkg::REQ_MOVE, 1'b1, 1'b1, 1'b1, '0, '0, '0);
		queue_req(msg_pkg::REQ_STOP, 1'b0, 1'b0, 1'b0, '0, '0, '0);
		queue_req(msg_pkg::REQ_STOP, 1'b0, 1'b1, 1'b0, '0, '0, '0);
		queue_req(msg_pkg::REQ_RESET, 1'b0, 1'b0, 1'b0, '0, '0, '0);
		queue_req(msg_pkg::REQ_CHECK, 1'b0, 1'b0, 1'b0, '0, 32'h8000_0000, 32'h0);
		queue_req(msg_pkg::REQ_CHECK, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000);
		queue_req(msg_pkg::REQ_CHECK, 1'b0, 1'b0, 1'b0, '0, 32'h0, 32'h7FFF_FFFF);
		drain();

		// finite move onto a target, then waiting in done
		write_reg(msg_pkg::CFG_AUTO_RESET, 32'h0);
		write_reg(msg_pkg::CFG_START_POSITION, 32'h0001_0000);
		write_reg(msg_pkg::CFG_TARGET_POSITION, 32'h0004_8000);
		write_reg(msg_pkg::CFG_FINITE_STEP, 32'h0001_0000);
		write_reg(msg_pkg::CFG_CONT_STEP, 32'h7FFF_FFFF);
		write_reg(msg_pkg::CFG_CYCLE_TIMES, 32'h0);
		write_reg(msg_pkg::CFG_TRAVEL_MIN, 32'h8000_0000);
		write_reg(msg_pkg::CFG_TRAVEL_MAX, 32'h7FFF_FFFF);
		queue_req(msg_pkg::REQ_MOVE, 1'b0, 1'b1, 1'b0, '0, '0, '0);
		clock_ms = clock_ms + 5;
		queue_req(msg_pkg::REQ_MOVE, 1'b0, 1'b1, 1'b0, '0, '0, '0);
		clock_ms = clock_ms + 5;
		queue_req(msg_pkg::REQ_MOVE, 1'b0, 1'b1, 1'b0, '0, '0, '0);
		clock_ms = clock_ms + 25;
		queue_req(msg_pkg::REQ_MOVE, 1'b0, 1'b1, 1'b0, '0, '0, '0);
		queue_req(msg_pkg::REQ_MOVE, 1'b1, 1'b1, 1'b1, '0, '0, '0);
		clock_ms = clock_ms + 10;
		queue_req(msg_pkg::REQ_MOVE, 1'b0, 1'b1, 1'b0, '0, '0, '0);
		clock_ms = clock_ms + 10;
		queue_req(msg_pkg::REQ_MOVE, 1'b0, 1'b1, 1'b0, '0, '0, '0);
		queue_req(msg_pkg::REQ_MOVE, 1'b0, 1'b1, 1'b0, '0, '0, '0);
		queue_req(msg_pkg::REQ_RESET, 1'b0, 1'b0, 1'b0, '0, '0, '0);
		// continuous move that saturates at the top of the range
		queue_req(msg_pkg::REQ_MOVE, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFF0, '0, '0);
		clock_ms = clock_ms + 10;
		queue_req(msg_pkg::REQ_MOVE, 1'b0, 1'b1, 1'b1, '0, '0, '0);
		clock_ms = clock_ms + 10;
		queue_req(msg_pkg::REQ_MOVE, 1'b1, 1'b1, 1'b1, '0, '0, '0);
		queue_req(msg_pkg::REQ_MOVE, 1'b1, 1'b1, 1'b0, '0, '0, '0);
		drain();

		// start refused at the upper limit
		write_reg(msg_pkg::CFG_AUTO_RESET, 32'h1);
		write_reg(msg_pkg::CFG_TRAVEL_MAX, 32'h0);
		write_reg(msg_pkg::CFG_TRAVEL_MIN, 32'hFFFF_0000);
		write_reg(msg_pkg::CFG_CONT_STEP, 32'h0000_4000);
		write_reg(msg_pkg::CFG_CYCLE_TIMES, 32'hFF0B);
		queue_req(msg_pkg::REQ_MOVE, 1'b1, 1'b1, 1'b1, 32'h0001_0000, '0, '0);
		clock_ms = clock_ms + 255;
		queue_req(msg_pkg::REQ_MOVE, 1'b1, 1'b1, 1'b1, '0, '0, '0);
		queue_req(msg_pkg::REQ_MOVE, 1'b1, 1'b1, 1'b0, 32'h0, '0, '0);
		queue_req(msg_pkg::REQ_STOP, 1'b0, 1'b1, 1'b0, '0, '0, '0);

		total = 0;
		while (total < 950) begin
			if (total < 317) begin
				send_idle_pct = 21;
				recv_idle_pct = 69;
			end else if (total < 634) begin
				send_idle_pct = 69;
				recv_idle_pct = 21;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_session(got);
			total += got;
		end

		guard = 0;
		while ((request_q.size() != 0 || in_valid || due_results.size() != 0) && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		if (due_results.size() != 0) begin
			$error("%0d result beats never arrived", due_results.size());
			fault_count++;
		end
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
